>>> sv/two_axis_slope_pd_controller_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the slope PD controller
// Shared property forms with clock and active-low reset gating.
// ----------------------------------------------------------------------------
`ifndef TWO_AXIS_SLOPE_PD_CONTROLLER_UNIT_MACROS_SVH
`define TWO_AXIS_SLOPE_PD_CONTROLLER_UNIT_MACROS_SVH

// same-cycle implication
`define TSPD_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("tspd: same-cycle check failed");

// next-cycle implication
`define TSPD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("tspd: next-cycle check failed");

`endif

>>> sv/tspd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tspd_pkg
// Widths, register codes, sequencer states and saturation for the controller.
// ----------------------------------------------------------------------------
package tspd_pkg;

  localparam int ANGLE_WIDTH = 16;
  localparam int ERR_W       = ANGLE_WIDTH + 1;
  localparam int DIFF_W      = ANGLE_WIDTH + 2;
  localparam int GAIN_W      = 16;
  localparam int SCALE_W     = 4;
  localparam int ACC_W       = 32;
  localparam int FRAC_SHIFT  = 8;
  localparam int KP_W        = GAIN_W + ERR_W;
  localparam int D_W         = GAIN_W + DIFF_W - FRAC_SHIFT;
  localparam int MUL_A_W     = (ACC_W > D_W) ? ACC_W : D_W;
  localparam int PROD_W      = MUL_A_W + GAIN_W;
  localparam int SUM_W       = MUL_A_W + SCALE_W + 1;
  localparam int SAT_W       = SUM_W + 1;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = GAIN_W;

  localparam logic FUNC_CLEAR = 1'b1;

  localparam logic [GAIN_W-1:0]  KP_RST    = GAIN_W'(655);
  localparam logic [GAIN_W-1:0]  KD_RST    = GAIN_W'(655);
  localparam logic [GAIN_W-1:0]  LIMIT_RST = GAIN_W'(13107);
  localparam logic [SCALE_W-1:0] PSCL_RST  = SCALE_W'(2);
  localparam logic [SCALE_W-1:0] DSCL_RST  = SCALE_W'(10);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KP_X,
    CFG_KP_Y,
    CFG_KD_X,
    CFG_KD_Y,
    CFG_STEP_LIMIT,
    CFG_P_SCALE,
    CFG_D_SCALE
  } cfg_idx_e;

  typedef struct packed {
    logic [GAIN_W-1:0]  kp_x;
    logic [GAIN_W-1:0]  kp_y;
    logic [GAIN_W-1:0]  kd_x;
    logic [GAIN_W-1:0]  kd_y;
    logic [GAIN_W-1:0]  step_limit;
    logic [SCALE_W-1:0] p_scale;
    logic [SCALE_W-1:0] d_scale;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_P_X,
    ST_P_Y,
    ST_D_X,
    ST_D_Y,
    ST_S_AX,
    ST_S_DX,
    ST_S_AY,
    ST_S_DY,
    ST_DONE
  } ctrl_state_e;

  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [SAT_W-1:0] v);
    logic [SAT_W-ACC_W:0] hi;
    hi = v[SAT_W-1:ACC_W-1];
    if (&hi || ~|hi) begin
      return v[ACC_W-1:0];
    end else if (v[SAT_W-1]) begin
      return {1'b1, {(ACC_W-1){1'b0}}};
    end else begin
      return {1'b0, {(ACC_W-1){1'b1}}};
    end
  endfunction

endpackage

>>> sv/tspd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tspd_if
// Valid/ready channels for the tilt word in and the drive word out.
// ----------------------------------------------------------------------------
interface tspd_in_if import tspd_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic                          func;
  logic signed [ANGLE_WIDTH-1:0] goal_x;
  logic signed [ANGLE_WIDTH-1:0] goal_y;
  logic signed [ANGLE_WIDTH-1:0] angle_x;
  logic signed [ANGLE_WIDTH-1:0] angle_y;

  modport source (output valid, func, goal_x, goal_y, angle_x, angle_y, input ready);
  modport sink   (input valid, func, goal_x, goal_y, angle_x, angle_y, output ready);
endinterface

interface tspd_out_if import tspd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [ACC_W-1:0] drive_x;
  logic signed [ACC_W-1:0] drive_y;
  logic                    too_fast;

  modport source (output valid, drive_x, drive_y, too_fast, input ready);
  modport sink   (input valid, drive_x, drive_y, too_fast, output ready);
endinterface

>>> sv/two_axis_slope_pd_controller_unit.sv
`timescale 1ns / 1ps
// One multiplier forms all eight products in sequence, one per cycle.
// The input is ready only while the sequencer is idle.
// Reset: gains, limit and scales to defaults, accumulators and last errors to
// zero, no result pending.
// ----------------------------------------------------------------------------
// two_axis_slope_pd_controller_unit
// Two-axis PD slope controller on a sequencer around one shared multiplier.
// ----------------------------------------------------------------------------
`include "two_axis_slope_pd_controller_unit_macros.svh"

module two_axis_slope_pd_controller_unit import tspd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  tspd_in_if.sink               in_i,
  tspd_out_if.source            out_o
);

  cfg_t        cfg;
  ctrl_state_e state_q, state_d;

  logic signed [ERR_W-1:0]   ex_q, ey_q, last_ex_q, last_ey_q, ex_in, ey_in;
  logic signed [DIFF_W-1:0]  dfx_q, dfy_q;
  logic signed [KP_W-1:0]    px_q, py_q, lim;
  logic signed [D_W-1:0]     dx_q, dy_q;
  logic signed [ACC_W-1:0]   accx_q, accy_q, ax_q, ay_q, drx_q, drv_w;
  logic signed [SUM_W-1:0]   sum_q;
  logic signed [MUL_A_W-1:0] mul_a;
  logic [GAIN_W-1:0]         mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic mul_en, in_acc, out_free, too_fast, commit, zero_st, ld_out, ld_tf;

  logic                    out_v_q, out_tf_q;
  logic signed [ACC_W-1:0] out_dx_q, out_dy_q;

  tspd_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .idx_i  (cfg_idx_i),
    .data_i (cfg_wdata_i),
    .cfg_o  (cfg)
  );

  tspd_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_free   = !out_v_q || out_o.ready;

  assign ex_in = ERR_W'(in_i.angle_x) - ERR_W'(in_i.goal_x);
  assign ey_in = ERR_W'(in_i.angle_y) - ERR_W'(in_i.goal_y);

  assign lim      = KP_W'({cfg.step_limit, {FRAC_SHIFT{1'b0}}});
  assign too_fast = (px_q > lim) || (px_q < -lim) || (py_q > lim) || (py_q < -lim);
  assign drv_w    = sat_acc(SAT_W'(sum_q) + SAT_W'(prod));

  always_comb begin
    state_d = state_q;
    mul_a   = '0;
    mul_b   = '0;
    mul_en  = (state_q != ST_DONE);
    commit  = 1'b0;
    zero_st = 1'b0;
    ld_out  = 1'b0;
    ld_tf   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = (in_i.func == FUNC_CLEAR) ? ST_CLEAR : ST_P_X;
        end
      end
      ST_CLEAR: begin
        if (out_free) begin
          zero_st = 1'b1;
          ld_out  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_P_X: begin
        mul_a   = MUL_A_W'(ex_q);
        mul_b   = cfg.kp_x;
        state_d = ST_P_Y;
      end
      ST_P_Y: begin
        mul_a   = MUL_A_W'(ey_q);
        mul_b   = cfg.kp_y;
        state_d = ST_D_X;
      end
      ST_D_X: begin
        mul_a   = MUL_A_W'(dfx_q);
        mul_b   = cfg.kd_x;
        state_d = ST_D_Y;
      end
      ST_D_Y: begin
        mul_a = MUL_A_W'(dfy_q);
        mul_b = cfg.kd_y;
        if (too_fast) begin
          if (out_free) begin
            ld_out  = 1'b1;
            ld_tf   = 1'b1;
            state_d = ST_IDLE;
          end
        end else begin
          state_d = ST_S_AX;
        end
      end
      ST_S_AX: begin
        mul_a   = MUL_A_W'(ax_q);
        mul_b   = GAIN_W'(cfg.p_scale);
        state_d = ST_S_DX;
      end
      ST_S_DX: begin
        mul_a   = MUL_A_W'(dx_q);
        mul_b   = GAIN_W'(cfg.d_scale);
        state_d = ST_S_AY;
      end
      ST_S_AY: begin
        mul_a   = MUL_A_W'(ay_q);
        mul_b   = GAIN_W'(cfg.p_scale);
        state_d = ST_S_DY;
      end
      ST_S_DY: begin
        mul_a   = MUL_A_W'(dy_q);
        mul_b   = GAIN_W'(cfg.d_scale);
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          commit  = 1'b1;
          ld_out  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ex_q  <= ex_in;
      ey_q  <= ey_in;
      dfx_q <= DIFF_W'(ex_in) - DIFF_W'(last_ex_q);
      dfy_q <= DIFF_W'(ey_in) - DIFF_W'(last_ey_q);
    end
    case (state_q)
      ST_P_Y: px_q <= KP_W'(prod);
      ST_D_X: py_q <= KP_W'(prod);
      ST_D_Y: begin
        dx_q <= D_W'(prod >>> FRAC_SHIFT);
        ax_q <= sat_acc(SAT_W'(accx_q) + SAT_W'(px_q >>> FRAC_SHIFT));
      end
      ST_S_AX: begin
        dy_q <= D_W'(prod >>> FRAC_SHIFT);
        ay_q <= sat_acc(SAT_W'(accy_q) + SAT_W'(py_q >>> FRAC_SHIFT));
      end
      ST_S_DX: sum_q <= SUM_W'(prod);
      ST_S_AY: drx_q <= drv_w;
      ST_S_DY: sum_q <= SUM_W'(prod);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accx_q    <= '0;
      accy_q    <= '0;
      last_ex_q <= '0;
      last_ey_q <= '0;
    end else if (zero_st) begin
      accx_q    <= '0;
      accy_q    <= '0;
      last_ex_q <= '0;
      last_ey_q <= '0;
    end else if (commit) begin
      accx_q    <= ax_q;
      accy_q    <= ay_q;
      last_ex_q <= ex_q;
      last_ey_q <= ey_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (ld_out) begin
      out_v_q <= 1'b1;
    end else if (out_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  // drives are zero unless a step word completes
  always_ff @(posedge clk_i) begin
    if (ld_out) begin
      out_tf_q <= ld_tf;
      out_dx_q <= commit ? drx_q : '0;
      out_dy_q <= commit ? drv_w : '0;
    end
  end

  assign out_o.valid    = out_v_q;
  assign out_o.drive_x  = out_dx_q;
  assign out_o.drive_y  = out_dy_q;
  assign out_o.too_fast = out_tf_q;

  `TSPD_ASSERT_IMPLY(a_fault_zero, clk_i, rst_ni, out_v_q && out_tf_q, out_dx_q == '0 && out_dy_q == '0)
  `TSPD_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, in_acc, state_q != ST_IDLE)
  `TSPD_ASSERT_NEXT(a_state_hold, clk_i, rst_ni, state_q != ST_DONE && state_q != ST_CLEAR, $stable(accx_q) && $stable(last_ey_q))

endmodule

>>> sv/tspd_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tspd_cfg
// Gain, limit and scale registers behind the indexed write port.
// ----------------------------------------------------------------------------
module tspd_cfg import tspd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  we_i,
  input  logic [CFG_IDX_W-1:0]  idx_i,
  input  logic [CFG_DATA_W-1:0] data_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      case (cfg_idx_e'(idx_i))
        CFG_KP_X:       cfg_d.kp_x       = data_i[GAIN_W-1:0];
        CFG_KP_Y:       cfg_d.kp_y       = data_i[GAIN_W-1:0];
        CFG_KD_X:       cfg_d.kd_x       = data_i[GAIN_W-1:0];
        CFG_KD_Y:       cfg_d.kd_y       = data_i[GAIN_W-1:0];
        CFG_STEP_LIMIT: cfg_d.step_limit = data_i[GAIN_W-1:0];
        CFG_P_SCALE:    cfg_d.p_scale    = data_i[SCALE_W-1:0];
        CFG_D_SCALE:    cfg_d.d_scale    = data_i[SCALE_W-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kp_x       <= KP_RST;
      cfg_q.kp_y       <= KP_RST;
      cfg_q.kd_x       <= KD_RST;
      cfg_q.kd_y       <= KD_RST;
      cfg_q.step_limit <= LIMIT_RST;
      cfg_q.p_scale    <= PSCL_RST;
      cfg_q.d_scale    <= DSCL_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> sv/tspd_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tspd_mul
// Shared signed-by-unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module tspd_mul import tspd_pkg::*; (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic signed [MUL_A_W-1:0] a_i,
  input  logic [GAIN_W-1:0]         b_i,
  output logic signed [PROD_W-1:0]  prod_o
);

  logic signed [PROD_W:0]   full;
  logic signed [PROD_W-1:0] prod_q;

  assign full = a_i * $signed({1'b0, b_i});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= full[PROD_W-1:0];
    end
  end

  assign prod_o = prod_q;

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the two-axis slope PD controller. Directed words
// cover reset gains, angle extremes, step-limit edges, clears and register
// writes. A ramp at the largest allowed step drives both accumulators far from
// zero. Random words then run under several gain settings and stall patterns.
// Every drive word is checked against an in-bench predictor.
// ----------------------------------------------------------------------------
module testbench;
  import tspd_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 16;
  localparam int MAX_REPORTS    = 10;
  localparam int RAMP_WORDS     = 400;
  localparam int PHASE_WORDS    = 130;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = '1;

  localparam longint ANGLE_MAX = 32767;
  localparam longint ANGLE_MIN = -32768;
  localparam longint ERR_MAX   = 65535;
  localparam longint ACC_MAX   = (longint'(1) <<< 31) - 1;
  localparam longint ACC_MIN   = -(longint'(1) <<< 31);

  typedef struct {
    logic                          func;
    logic signed [ANGLE_WIDTH-1:0] goal_x;
    logic signed [ANGLE_WIDTH-1:0] goal_y;
    logic signed [ANGLE_WIDTH-1:0] angle_x;
    logic signed [ANGLE_WIDTH-1:0] angle_y;
  } tilt_word_t;

  typedef struct {
    logic signed [ACC_W-1:0] drive_x;
    logic signed [ACC_W-1:0] drive_y;
    logic                    too_fast;
  } drive_word_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  tspd_in_if  in_ch ();
  tspd_out_if out_ch ();

  two_axis_slope_pd_controller_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  cfg_t        gains;
  longint      accum [2];
  longint      prev_err [2];
  drive_word_t expected_drives [$];

  int src_idle_pct = 17;
  int snk_idle_pct = 67;
  int mismatches   = 0;
  int words_sent   = 0;
  int drives_seen  = 0;
  int clear_count  = 0;
  int fault_count  = 0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic longint clamp32(input longint v);
    if (v > ACC_MAX) return ACC_MAX;
    if (v < ACC_MIN) return ACC_MIN;
    return v;
  endfunction

  function automatic longint mag(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Advance the controller state by one tilt word and return its drive word.
  function automatic drive_word_t pd_step(input tilt_word_t w);
    longint      err [2];
    longint      kp [2];
    longint      kd [2];
    longint      prop [2];
    longint      deriv [2];
    longint      acc_next [2];
    longint      drive [2];
    longint      lim;
    drive_word_t r;
    r.drive_x  = '0;
    r.drive_y  = '0;
    r.too_fast = 1'b0;
    if (w.func == FUNC_CLEAR) begin
      accum    = '{0, 0};
      prev_err = '{0, 0};
      clear_count++;
      return r;
    end
    err[0] = longint'(w.angle_x) - longint'(w.goal_x);
    err[1] = longint'(w.angle_y) - longint'(w.goal_y);
    kp[0]  = longint'(gains.kp_x);
    kp[1]  = longint'(gains.kp_y);
    kd[0]  = longint'(gains.kd_x);
    kd[1]  = longint'(gains.kd_y);
    lim    = longint'(gains.step_limit) * 256;
    for (int i = 0; i < 2; i++) prop[i] = kp[i] * err[i];
    if (mag(prop[0]) > lim || mag(prop[1]) > lim) begin
      r.too_fast = 1'b1;
      fault_count++;
      return r;
    end
    for (int i = 0; i < 2; i++) begin
      deriv[i]    = (kd[i] * (err[i] - prev_err[i])) >>> 8;
      acc_next[i] = clamp32(accum[i] + (prop[i] >>> 8));
      accum[i]    = acc_next[i];
      prev_err[i] = err[i];
      drive[i]    = clamp32(longint'(gains.p_scale) * acc_next[i]
                            + longint'(gains.d_scale) * deriv[i]);
    end
    r.drive_x = ACC_W'(drive[0]);
    r.drive_y = ACC_W'(drive[1]);
    return r;
  endfunction

  function automatic tilt_word_t tilt(input logic func, input longint gx, input longint ax,
                                      input longint gy, input longint ay);
    tilt_word_t w;
    w.func    = func;
    w.goal_x  = ANGLE_WIDTH'(gx);
    w.angle_x = ANGLE_WIDTH'(ax);
    w.goal_y  = ANGLE_WIDTH'(gy);
    w.angle_y = ANGLE_WIDTH'(ay);
    return w;
  endfunction

  // Pick a goal so that goal + err stays inside the angle range.
  function automatic longint goal_for(input longint err);
    longint lo;
    longint hi;
    lo = (ANGLE_MIN - err > ANGLE_MIN) ? ANGLE_MIN - err : ANGLE_MIN;
    hi = (ANGLE_MAX - err < ANGLE_MAX) ? ANGLE_MAX - err : ANGLE_MAX;
    return lo + longint'($urandom_range(int'(hi - lo)));
  endfunction

  function automatic tilt_word_t axis_word(input longint ex, input longint ey);
    longint gx;
    longint gy;
    gx = goal_for(ex);
    gy = goal_for(ey);
    return tilt(1'b0, gx, gx + ex, gy, gy + ey);
  endfunction

  // Error within the step limit for this gain, or beyond it when asked.
  function automatic longint pick_error(input logic [GAIN_W-1:0] kp, input bit over);
    longint reach;
    longint e;
    reach = (kp == 0) ? ERR_MAX : (longint'(gains.step_limit) * 256) / longint'(kp);
    if (reach > ERR_MAX) reach = ERR_MAX;
    if (over && reach < ERR_MAX)
      e = reach + 1 + longint'($urandom_range(int'(ERR_MAX - reach - 1)));
    else if ($urandom_range(9) == 0)
      e = reach;
    else
      e = longint'($urandom_range(int'(reach)));
    return ($urandom_range(1) == 1) ? -e : e;
  endfunction

  function automatic tilt_word_t random_tilt();
    tilt_word_t w;
    int         pick;
    bit         over_x;
    bit         over_y;
    pick   = $urandom_range(99);
    over_x = 1'b0;
    over_y = 1'b0;
    if (pick < 15) begin
      w.func    = (pick < 5) ? FUNC_CLEAR : 1'b0;
      w.goal_x  = ANGLE_WIDTH'($urandom);
      w.goal_y  = ANGLE_WIDTH'($urandom);
      w.angle_x = ANGLE_WIDTH'($urandom);
      w.angle_y = ANGLE_WIDTH'($urandom);
      return w;
    end
    if (pick < 25) begin
      if ($urandom_range(1) == 1) over_x = 1'b1;
      else over_y = 1'b1;
    end
    return axis_word(pick_error(gains.kp_x, over_x), pick_error(gains.kp_y, over_y));
  endfunction

  task automatic set_idling(input int src_pct, input int snk_pct);
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
  endtask

  // Hold valid across words unless a gap is drawn; predict at the accepting edge.
  task automatic send_tilt(input tilt_word_t w);
    if ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    in_ch.valid   <= 1'b1;
    in_ch.func    <= w.func;
    in_ch.goal_x  <= w.goal_x;
    in_ch.goal_y  <= w.goal_y;
    in_ch.angle_x <= w.angle_x;
    in_ch.angle_y <= w.angle_y;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    expected_drives.insert(expected_drives.size(), pd_step(w));
    words_sent++;
  endtask

  task automatic drain_drives();
    in_ch.valid <= 1'b0;
    while (expected_drives.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_KP_X:       gains.kp_x       = value;
      CFG_KP_Y:       gains.kp_y       = value;
      CFG_KD_X:       gains.kd_x       = value;
      CFG_KD_Y:       gains.kd_y       = value;
      CFG_STEP_LIMIT: gains.step_limit = value;
      CFG_P_SCALE:    gains.p_scale    = value[SCALE_W-1:0];
      CFG_D_SCALE:    gains.d_scale    = value[SCALE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_gains(input cfg_t c);
    drain_drives();
    write_reg(CFG_KP_X, c.kp_x);
    write_reg(CFG_KP_Y, c.kp_y);
    write_reg(CFG_KD_X, c.kd_x);
    write_reg(CFG_KD_Y, c.kd_y);
    write_reg(CFG_STEP_LIMIT, c.step_limit);
    write_reg(CFG_P_SCALE, CFG_DATA_W'(c.p_scale));
    write_reg(CFG_D_SCALE, CFG_DATA_W'(c.d_scale));
  endtask

  task automatic test_defaults();
    send_tilt(tilt(1'b0, 0, 0, 0, 0));
    send_tilt(tilt(1'b0, 100, 356, -50, -40));
    send_tilt(tilt(1'b0, 0, -5120, 0, 5120));
    send_tilt(tilt(1'b0, 0, 5200, 0, 0));
    send_tilt(tilt(FUNC_CLEAR, 1234, -1, -77, 300));
    send_tilt(tilt(1'b0, 0, 64, 0, -64));
  endtask

  task automatic test_field_extremes();
    cfg_t c;
    c            = gains;
    c.kp_x       = 16'd1;
    c.kp_y       = 16'd1;
    c.kd_x       = '1;
    c.kd_y       = '1;
    c.step_limit = '1;
    c.p_scale    = '1;
    c.d_scale    = '1;
    program_gains(c);
    send_tilt(tilt(1'b0, ANGLE_MIN, ANGLE_MAX, ANGLE_MAX, ANGLE_MIN));
    send_tilt(tilt(1'b0, ANGLE_MAX, ANGLE_MIN, ANGLE_MIN, ANGLE_MAX));
    send_tilt(tilt(1'b0, ANGLE_MIN, ANGLE_MIN, ANGLE_MAX, ANGLE_MAX));
    send_tilt(tilt(1'b0, ANGLE_MAX, ANGLE_MAX, ANGLE_MIN, ANGLE_MIN));
    send_tilt(tilt(FUNC_CLEAR, ANGLE_MIN, ANGLE_MAX, ANGLE_MAX, ANGLE_MIN));
  endtask

  task automatic test_step_limit();
    cfg_t c;
    c            = gains;
    c.kp_x       = 16'd256;
    c.kp_y       = 16'd512;
    c.step_limit = 16'd100;
    c.p_scale    = 4'd2;
    c.d_scale    = 4'd10;
    program_gains(c);
    send_tilt(axis_word(100, 0));
    send_tilt(axis_word(101, 0));
    send_tilt(axis_word(-101, 50));
    send_tilt(axis_word(-100, 0));
    send_tilt(axis_word(0, 50));
    send_tilt(axis_word(100, -51));
  endtask

  task automatic test_register_writes();
    cfg_t c;
    c            = gains;
    c.kp_x       = 16'h00FF;
    c.kp_y       = 16'h0100;
    c.step_limit = '1;
    program_gains(c);
    write_reg(CFG_UNUSED, 16'h0001);
    write_reg(CFG_P_SCALE, 16'hFFF3);
    write_reg(CFG_D_SCALE, 16'hA7A7);
    send_tilt(axis_word(300, -300));
    send_tilt(axis_word(-200, 200));
  endtask

  // Push x up and y down at the largest allowed step.
  task automatic test_saturation_ramp();
    cfg_t c;
    c = '1;
    set_idling(0, 0);
    program_gains(c);
    send_tilt(tilt(FUNC_CLEAR, 0, 0, 0, 0));
    repeat (RAMP_WORDS)
      send_tilt(axis_word(256 - longint'($urandom_range(3)),
                          -(256 - longint'($urandom_range(3)))));
    repeat (8) send_tilt(axis_word(-256, 256));
    send_tilt(tilt(FUNC_CLEAR, 0, 0, 0, 0));
  endtask

  task automatic test_random_phases();
    cfg_t c;
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: set_idling(17, 67);
        1: set_idling(67, 17);
        default: set_idling(0, 0);
      endcase
      for (int k = 0; k < 4; k++) begin
        if (k == 0) begin
          c = '1;
        end else if (k == 1) begin
          c = '0;
        end else begin
          c.kp_x       = GAIN_W'($urandom_range(65535) >> $urandom_range(15));
          c.kp_y       = GAIN_W'($urandom_range(65535) >> $urandom_range(15));
          c.kd_x       = GAIN_W'($urandom_range(65535) >> $urandom_range(15));
          c.kd_y       = GAIN_W'($urandom_range(65535) >> $urandom_range(15));
          c.step_limit = GAIN_W'($urandom);
          c.p_scale    = SCALE_W'($urandom);
          c.d_scale    = SCALE_W'($urandom);
        end
        program_gains(c);
        repeat (PHASE_WORDS) send_tilt(random_tilt());
      end
    end
  endtask

  initial begin : drive_checker
    drive_word_t exp_w;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        drives_seen++;
        if (expected_drives.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected drive word: x=%0d y=%0d too_fast=%0b",
                     out_ch.drive_x, out_ch.drive_y, out_ch.too_fast);
        end else begin
          exp_w = expected_drives.pop_front();
          if (out_ch.drive_x !== exp_w.drive_x || out_ch.drive_y !== exp_w.drive_y ||
              out_ch.too_fast !== exp_w.too_fast) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("drive word %0d: expected x=%0d y=%0d too_fast=%0b, got x=%0d y=%0d too_fast=%0b",
                       drives_seen, exp_w.drive_x, exp_w.drive_y, exp_w.too_fast,
                       out_ch.drive_x, out_ch.drive_y, out_ch.too_fast);
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
        quiet = 0;
      else
        quiet++;
    end
    $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
    $display("status: fail");
    $finish;
  end

  initial begin : main
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= '0;
    cfg_wdata_i   <= '0;
    in_ch.valid   <= 1'b0;
    in_ch.func    <= 1'b0;
    in_ch.goal_x  <= '0;
    in_ch.goal_y  <= '0;
    in_ch.angle_x <= '0;
    in_ch.angle_y <= '0;
    gains.kp_x       = KP_RST;
    gains.kp_y       = KP_RST;
    gains.kd_x       = KD_RST;
    gains.kd_y       = KD_RST;
    gains.step_limit = LIMIT_RST;
    gains.p_scale    = PSCL_RST;
    gains.d_scale    = DSCL_RST;
    accum    = '{0, 0};
    prev_err = '{0, 0};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_defaults();
    test_field_extremes();
    test_step_limit();
    test_register_writes();
    test_saturation_ramp();
    test_random_phases();
    drain_drives();
    $display("covered %0d tilt words (%0d clears, %0d step-limit faults) over directed,",
             words_sent, clear_count, fault_count);
    $display("full-step ramp and random gain phases; %0d drive words seen, %0d mismatches",
             drives_seen, mismatches);
    if (mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

>>> files.f
+incdir+sv
sv/tspd_pkg.sv
sv/tspd_if.sv
sv/tspd_cfg.sv
sv/tspd_mul.sv
sv/two_axis_slope_pd_controller_unit.sv
tb/sv/testbench.sv
